[src/srp_pkg.sv]
package srp_pkg;

   localparam int GridSide  = 33;
   localparam int MaxPairs  = 6;
   localparam int FrameMax  = 1024;
   localparam int AngleBins = 360;

   localparam int CorrSpan  = 2 * FrameMax;
   localparam int CorrDepth = MaxPairs * CorrSpan;
   localparam int LagDepth  = GridSide * GridSide * MaxPairs;
   localparam int PickTol   = 3;

   localparam int CorrAw = $clog2(CorrDepth);
   localparam int LagAw  = $clog2(LagDepth);
   localparam int BinAw  = $clog2(AngleBins);
   localparam int PairW  = $clog2(MaxPairs + 1);
   localparam int PointW = $clog2(GridSide * GridSide);
   localparam int SumW   = 19;

   localparam logic [1:0] ModeLoadCorr = 2'd0;
   localparam logic [1:0] ModeLoadLag  = 2'd1;
   localparam logic [1:0] ModeRun      = 2'd2;

   localparam logic CsrPairs = 1'b0;
   localparam logic CsrFrame = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_ACCUM,
      ST_SCAN,
      ST_EMIT
   } state_type;

   function automatic longint atan_udeg(input int i);
      case (i)
         0: return 45000000;   1: return 26565051;  2: return 14036243;
         3: return 7125016;    4: return 3576334;   5: return 1789911;
         6: return 895174;     7: return 447614;    8: return 223811;
         9: return 111906;     10: return 55953;    11: return 27976;
         12: return 13988;     13: return 6994;     14: return 3497;
         15: return 1749;      16: return 874;      17: return 437;
         18: return 219;       19: return 109;      20: return 55;
         default: return 0;
      endcase
   endfunction

   // Angle bin of a grid point by integer CORDIC vectoring, as a build-time table.
   function automatic logic [8:0] point_bin(input int col, input int row);
      longint x, y, acc, dx, dy, b;
      x = 2 * col - (GridSide - 1);
      y = (GridSide - 1) - 2 * row;
      acc = 0;
      if (x == 0 && y == 0) return 9'd0;
      if (x < 0) begin
         x = -x;
         y = -y;
         acc = 180000000;
      end
      x = x * 16777216;
      y = y * 16777216;
      for (int i = 0; i < 21; i++) begin
         dx = (y >= 0) ? (y >>> i) : -((-y) >>> i);
         dy = (x >= 0) ? (x >>> i) : -((-x) >>> i);
         if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            acc = acc + atan_udeg(i);
         end else begin
            x = x - dx;
            y = y + dy;
            acc = acc - atan_udeg(i);
         end
      end
      if (acc < 0) acc = acc + 360000000;
      if (acc >= 360000000) acc = acc - 360000000;
      b = (acc + 500000) / 1000000;
      if (b >= AngleBins) b = b - AngleBins;
      return b[8:0];
   endfunction

endpackage

[src/steered_response_direction_pick_core.sv]
// Steered-response direction picker. Load requests (mode 0: correlation
// sample, mode 1: lag entry) are taken one per cycle while no run is in
// progress and write the correlation or lag memory. A run request (mode
// 2) clears the 360 angle bins, then walks all 1089 grid points; each
// pair of each point is one pipelined pass through the lag memory and
// the correlation memory. Each point's sum is read-modified-written into
// the bin memory, with forwarding when one of the two previous points
// lands in the same bin. A first scan finds the maximum and a second scan
// picks the first bin within 3 LSB of it. The run then presents a single
// response holding the bin and the clip flag; a new request is accepted
// once that response is taken. Configuration writes are taken only while
// no run is in progress. Correlation and lag entries that were never
// written read as undefined values.
module steered_response_direction_pick_core import srp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic [2:0]         req_pair,
   input  logic [10:0]        req_lag_index,
   input  logic [5:0]         req_grid_col,
   input  logic [5:0]         req_grid_row,
   input  logic signed [15:0] req_gcc_sample,
   input  logic signed [11:0] req_delay_lag,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [8:0]         rsp_direction,
   output logic               rsp_lag_clipped,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [10:0]        csr_data
);

   state_type state_ff, state_in;

   logic [2:0]  pairs_ff;
   logic [10:0] frame_ff;
   logic [PairW-1:0] np;
   logic [10:0] fl;

   // counters
   logic [BinAw-1:0]  bin_cnt_ff, bin_cnt_in;
   logic              scan_pass_ff, scan_pass_in;
   logic [PointW-1:0] pt_ff, pt_in;
   logic [2:0]        pk_ff, pk_in;
   logic              walk_done_ff, walk_done_in;

   // pipeline: stage1 lag read, stage2 corr read, stage3 sum, bin rmw
   logic              s1_v_ff, s1_last_ff, s1_first_ff;
   logic [2:0]        s1_pk_ff;
   logic [PointW-1:0] s1_pt_ff;
   logic              s2_v_ff, s2_last_ff, s2_first_ff;
   logic              s3_v_ff;
   logic [BinAw-1:0]  s3_bin_ff;
   logic signed [SumW-1:0] s3_sum_ff;
   logic signed [SumW-1:0] acc_ff;
   logic              s4_v_ff;
   logic [BinAw-1:0]  s4_bin_ff;
   logic signed [31:0] s4_new_ff;
   logic              s5_v_ff;
   logic [BinAw-1:0]  s5_bin_ff;
   logic signed [31:0] s5_new_ff;

   logic clip_ff;
   logic signed [31:0] best_ff;
   logic [8:0] pick_ff;
   logic       found_ff;

   // accept
   logic req_acc;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         pairs_ff <= 3'd6;
         frame_ff <= 11'd512;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CsrPairs: pairs_ff <= csr_data[2:0];
            CsrFrame: frame_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      np = (pairs_ff == 3'd0) ? PairW'(1) :
           (pairs_ff > 3'(MaxPairs)) ? PairW'(MaxPairs) : PairW'(pairs_ff);
      fl = (frame_ff < 11'd2) ? 11'd2 :
           (frame_ff > 11'(FrameMax)) ? 11'(FrameMax) : frame_ff;
   end

   // memories
   logic              corr_we, lag_we;
   logic [CorrAw-1:0] corr_wa, corr_ra;
   logic [LagAw-1:0]  lag_wa, lag_ra;
   logic [15:0]       corr_rd;
   logic [11:0]       lag_rd;
   logic              bin_we;
   logic [BinAw-1:0]  bin_wa, bin_ra;
   logic [31:0]       bin_wd, bin_rd;

   assign corr_we = req_acc && req_mode == ModeLoadCorr &&
                    req_pair < 3'(MaxPairs);
   assign corr_wa = CorrAw'(req_pair * CorrSpan + req_lag_index);
   assign lag_we  = req_acc && req_mode == ModeLoadLag && req_pair < 3'(MaxPairs) &&
                    req_grid_col < 6'(GridSide) && req_grid_row < 6'(GridSide);
   assign lag_wa  = LagAw'((req_grid_row * GridSide + req_grid_col) * MaxPairs
                    + req_pair);

   srp_ram #(.Width(16), .Depth(CorrDepth)) u_corr (
      .clock, .wr_en(corr_we), .wr_addr(corr_wa), .wr_data(req_gcc_sample),
      .rd_addr(corr_ra), .rd_data(corr_rd));
   srp_ram #(.Width(12), .Depth(LagDepth)) u_lag (
      .clock, .wr_en(lag_we), .wr_addr(lag_wa), .wr_data(req_delay_lag),
      .rd_addr(lag_ra), .rd_data(lag_rd));
   srp_ram #(.Width(32), .Depth(AngleBins)) u_bins (
      .clock, .wr_en(bin_we), .wr_addr(bin_wa), .wr_data(bin_wd),
      .rd_addr(bin_ra), .rd_data(bin_rd));

   // walk address generation
   logic walk_issue;
   assign walk_issue = (state_ff == ST_ACCUM) && !walk_done_ff;
   assign lag_ra = LagAw'(pt_ff * MaxPairs + pk_ff);

   always_comb begin
      pt_in = pt_ff;
      pk_in = pk_ff;
      walk_done_in = walk_done_ff;
      if (state_ff == ST_CLEAR) begin
         pt_in = '0;
         pk_in = '0;
         walk_done_in = 1'b0;
      end else if (walk_issue) begin
         if (PairW'(pk_ff) + PairW'(1) >= np) begin
            pk_in = '0;
            if (pt_ff == PointW'(GridSide * GridSide - 1)) walk_done_in = 1'b1;
            else pt_in = pt_ff + PointW'(1);
         end else begin
            pk_in = pk_ff + 3'd1;
         end
      end
   end

   // stage2 corr address from lag read; lag is signed 12 bits stored
   logic signed [12:0] pos;
   logic [11:0] pos_c;
   logic clip_hit;
   always_comb begin
      pos = $signed({2'b00, fl}) - 13'sd1 + 13'($signed(lag_rd));
      clip_hit = 1'b0;
      if (pos < 0) begin
         pos_c = '0;
         clip_hit = 1'b1;
      end else if (pos > $signed({1'b0, fl, 1'b0}) - 13'sd1) begin
         pos_c = 12'({fl, 1'b0} - 12'd1);
         clip_hit = 1'b1;
      end else begin
         pos_c = pos[11:0];
      end
   end
   assign corr_ra = CorrAw'(s1_pk_ff * CorrSpan + pos_c);

   // bin of the point lands in stage2 alongside its correlation sample
   logic [BinAw-1:0] pt_bin;
   srp_bin_table u_tbl (.clock, .point(s1_pt_ff), .bin(pt_bin));

   logic signed [SumW-1:0] acc_cur;
   assign acc_cur = (s2_first_ff ? '0 : acc_ff) + SumW'($signed(corr_rd));

   // bin rmw: read at s3 issue, write at s4; forward the two writes the read missed
   logic signed [31:0] old_val;
   logic signed [32:0] tsum;
   logic signed [31:0] sat;
   always_comb begin
      if (s4_v_ff && s4_bin_ff == s3_bin_ff) old_val = s4_new_ff;
      else if (s5_v_ff && s5_bin_ff == s3_bin_ff) old_val = s5_new_ff;
      else old_val = $signed(bin_rd);
      tsum = 33'(old_val) + 33'(s3_sum_ff);
      if (tsum > 33'sh07FFFFFFF) sat = 32'sh7FFFFFFF;
      else if (tsum < -33'sh080000000) sat = 32'sh80000000;
      else sat = tsum[31:0];
   end

   always_comb begin
      bin_we = 1'b0;
      bin_wa = s4_bin_ff;
      bin_wd = s4_new_ff;
      bin_ra = bin_cnt_ff;
      if (state_ff == ST_CLEAR) begin
         bin_we = 1'b1;
         bin_wa = bin_cnt_ff;
         bin_wd = '0;
      end else if (state_ff == ST_ACCUM) begin
         bin_we = s4_v_ff;
         bin_ra = pt_bin;
      end
   end

   logic pipe_busy;
   assign pipe_busy = s1_v_ff || s2_v_ff || s3_v_ff || s4_v_ff;

   // scan: read address bin_cnt, data valid next cycle
   logic scan_rd_v_ff;
   logic [BinAw-1:0] scan_idx_ff;
   logic scan_end;
   assign scan_end = (bin_cnt_ff == BinAw'(AngleBins - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_acc && req_mode == ModeRun) state_in = ST_CLEAR;
         ST_CLEAR: if (scan_end) state_in = ST_ACCUM;
         ST_ACCUM: if (walk_done_ff && !walk_issue && !pipe_busy) state_in = ST_SCAN;
         ST_SCAN:  if (scan_pass_ff && scan_rd_v_ff &&
                       scan_idx_ff == BinAw'(AngleBins - 1)) state_in = ST_EMIT;
         ST_EMIT:  if (!rsp_stall) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      bin_cnt_in = bin_cnt_ff;
      scan_pass_in = scan_pass_ff;
      case (state_ff)
         ST_IDLE: begin
            bin_cnt_in = '0;
            scan_pass_in = 1'b0;
         end
         ST_CLEAR: bin_cnt_in = scan_end ? '0 : bin_cnt_ff + BinAw'(1);
         ST_SCAN: begin
            if (!scan_end) bin_cnt_in = bin_cnt_ff + BinAw'(1);
            if (scan_rd_v_ff && scan_idx_ff == BinAw'(AngleBins - 1)) begin
               scan_pass_in = 1'b1;
               bin_cnt_in = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bin_cnt_ff <= '0;
         scan_pass_ff <= 1'b0;
         pt_ff <= '0;
         pk_ff <= '0;
         walk_done_ff <= 1'b1;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         scan_rd_v_ff <= 1'b0;
         clip_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         bin_cnt_ff <= bin_cnt_in;
         scan_pass_ff <= scan_pass_in;
         pt_ff <= pt_in;
         pk_ff <= pk_in;
         walk_done_ff <= walk_done_in;
         s1_v_ff <= walk_issue;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff && s2_last_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
         // advance the scan read pipeline, hold off at the pass turnaround
         scan_rd_v_ff <= (state_ff == ST_SCAN) && !(scan_rd_v_ff &&
                         scan_idx_ff == BinAw'(AngleBins - 1));
         if (state_ff == ST_CLEAR) clip_ff <= 1'b0;
         else if (s1_v_ff && clip_hit) clip_ff <= 1'b1;
         if (state_ff == ST_CLEAR) found_ff <= 1'b0;
         else if (state_ff == ST_SCAN && scan_pass_ff && scan_rd_v_ff && !found_ff &&
                  33'($signed(bin_rd)) >= 33'(best_ff) - 33'(PickTol))
            found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      s1_pk_ff <= pk_ff;
      s1_pt_ff <= pt_ff;
      s1_first_ff <= (pk_ff == 3'd0);
      s1_last_ff <= (PairW'(pk_ff) + PairW'(1) >= np);
      s2_first_ff <= s1_first_ff;
      s2_last_ff <= s1_last_ff;
      if (s2_v_ff) acc_ff <= acc_cur;
      s3_sum_ff <= acc_cur;
      s3_bin_ff <= pt_bin;
      s4_bin_ff <= s3_bin_ff;
      s4_new_ff <= sat;
      s5_bin_ff <= s4_bin_ff;
      s5_new_ff <= s4_new_ff;
      scan_idx_ff <= bin_cnt_ff;
      if (state_ff == ST_SCAN && !scan_pass_ff && scan_rd_v_ff) begin
         if (scan_idx_ff == '0 || $signed(bin_rd) > best_ff) best_ff <= $signed(bin_rd);
      end
      if (state_ff == ST_SCAN && scan_pass_ff && scan_rd_v_ff && !found_ff &&
          33'($signed(bin_rd)) >= 33'(best_ff) - 33'(PickTol))
         pick_ff <= 9'(scan_idx_ff);
   end

   assign rsp_valid       = (state_ff == ST_EMIT);
   assign rsp_direction   = pick_ff;
   assign rsp_lag_clipped = clip_ff;

endmodule

[src/srp_ram.sv]
module srp_ram #(
   parameter int Width = 16,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/srp_bin_table.sv]
// Point-to-angle-bin lookup, indexed by linear grid point, registered read.
module srp_bin_table import srp_pkg::*; (
   input  logic              clock,
   input  logic [PointW-1:0] point,
   output logic [BinAw-1:0]  bin
);

   logic [8:0] table_rom [GridSide * GridSide];
   logic [BinAw-1:0] bin_ff;

   always_comb begin
      for (int r = 0; r < GridSide; r++) begin
         for (int c = 0; c < GridSide; c++) begin
            table_rom[r * GridSide + c] = point_bin(c, r);
         end
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= table_rom[point][BinAw-1:0];
   end

   assign bin = bin_ff;

endmodule

[src/srp_checker.sv]
module srp_checker import srp_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [1:0] req_mode,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [8:0] rsp_direction
);

   a_dir_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_direction < 9'(AngleBins)) else $error("direction out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_direction))
      else $error("response dropped while stalled");

   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken with response pending");

   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_mode == ModeRun |=> req_stall)
      else $error("run did not block requests");

endmodule

bind steered_response_direction_pick_core srp_checker u_chk (
   .clock, .reset, .req_valid, .req_stall, .req_mode,
   .rsp_valid, .rsp_stall, .rsp_direction);
